// ===== rtl/core/cch_pkg.sv =====
// cch_pkg: shared constants, opcodes, register indexes and control types
// for the counter coincidence histogram; used by every module in rtl/core.
// no dependencies
`default_nettype none

package cch_pkg;

	localparam int MAX_HITS_DEF     = 64;
	localparam int MAX_COUNTERS_DEF = 32;
	localparam int TIME_WIDTH_DEF   = 48;

	localparam int ID_W   = 8;
	localparam int BIN_W  = 5;
	localparam int WIN_W  = 31;
	localparam int CNT_W  = 32;
	localparam int EVT_W  = 13;
	localparam int CIDX_W = 3;

	localparam logic OP_HIT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CIDX_W-1:0] REG_FIRST_LOW   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_FIRST_HIGH  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_SECOND_LOW  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_SECOND_HIGH = 3'd3;
	localparam logic [CIDX_W-1:0] REG_WINDOW      = 3'd4;

	localparam logic [ID_W-1:0]  FIRST_LOW_RST   = 8'd0;
	localparam logic [ID_W-1:0]  FIRST_HIGH_RST  = 8'd31;
	localparam logic [ID_W-1:0]  SECOND_LOW_RST  = 8'd32;
	localparam logic [ID_W-1:0]  SECOND_HIGH_RST = 8'd63;
	localparam logic [WIN_W-1:0] WINDOW_RST      = '0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} cch_state_t;

	typedef struct packed {
		logic clear_step;
		logic hit_load;
		logic read_issue;
		logic walk_init;
		logic walk_issue;
		logic evt_close;
		logic out_load_evt;
		logic out_load_read;
	} cch_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic walk_empty;
		logic walk_last;
		logic pipe_busy;
	} cch_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/cch_ctrl.sv =====
// cch_ctrl: controller state machine, request handshakes and output valid
// depends on cch_pkg
`default_nettype none

module cch_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 operation,
	input  wire logic                 end_of_event,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output cch_pkg::cch_cmd_t         cmd,
	input  wire cch_pkg::cch_status_t status
);

	cch_pkg::cch_state_t state_q, state_d;
	logic                out_valid_q;
	logic                out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cch_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load_evt || cmd.out_load_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			cch_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_last) begin
					state_d = cch_pkg::ST_IDLE;
				end
			end
			cch_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (operation == cch_pkg::OP_READ) begin
						cmd.read_issue = 1'b1;
						state_d        = cch_pkg::ST_READ;
					end else begin
						cmd.hit_load = 1'b1;
						if (end_of_event) begin
							cmd.walk_init = 1'b1;
							state_d       = cch_pkg::ST_WALK;
						end
					end
				end
			end
			cch_pkg::ST_WALK: begin
				if (status.walk_empty) begin
					state_d = cch_pkg::ST_DRAIN;
				end else begin
					cmd.walk_issue = 1'b1;
					if (status.walk_last) begin
						state_d = cch_pkg::ST_DRAIN;
					end
				end
			end
			cch_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = cch_pkg::ST_DONE;
				end
			end
			cch_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.out_load_evt = 1'b1;
					cmd.evt_close    = 1'b1;
					state_d          = cch_pkg::ST_IDLE;
				end
			end
			cch_pkg::ST_READ: begin
				if (out_free) begin
					cmd.out_load_read = 1'b1;
					state_d           = cch_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cch_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/cch_hit_list.sv =====
// cch_hit_list: one hit list memory holding counter offset and timestamp,
// one write and one registered read per cycle; depends on cch_pkg
`default_nettype none

module cch_hit_list #(
	parameter int DEPTH = cch_pkg::MAX_HITS_DEF,
	parameter int TW    = cch_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [cch_pkg::ID_W-1:0] wr_off,
	input  wire logic [TW-1:0]           wr_time,
	input  wire logic                    rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [cch_pkg::ID_W-1:0]     rd_off,
	output logic [TW-1:0]                rd_time
);

	localparam int EW = cch_pkg::ID_W + TW;

	logic [EW-1:0] mem_q [DEPTH];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_off, wr_time};
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_off  = rd_q[EW-1:TW];
	assign rd_time = rd_q[TW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/cch_hist.sv =====
// cch_hist: pair histogram memory with clearing sweep, registered read and
// saturating read-modify-write with write forwarding; depends on cch_pkg
`default_nettype none

module cch_hist #(
	parameter int CW = $clog2(cch_pkg::MAX_COUNTERS_DEF)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     clear_step,
	output logic                          clear_last,
	input  wire logic                     rd_en,
	input  wire logic [2*CW-1:0]          rd_addr,
	output logic [cch_pkg::CNT_W-1:0]     rd_data,
	input  wire logic                     inc_en,
	input  wire logic [2*CW-1:0]          inc_addr
);

	localparam int AW    = 2 * CW;
	localparam int DEPTH = 2 ** AW;

	logic [cch_pkg::CNT_W-1:0] mem_q [DEPTH];
	logic [cch_pkg::CNT_W-1:0] rd_q;
	logic [AW-1:0]             clr_q;
	logic                      wr_valid_q;
	logic [AW-1:0]             wr_addr_q;
	logic [cch_pkg::CNT_W-1:0] wr_data_q;
	logic [cch_pkg::CNT_W-1:0] fwd;
	logic [cch_pkg::CNT_W-1:0] inc_val;

	assign clear_last = &clr_q;
	assign rd_data    = rd_q;

	// latest write is not yet visible in the registered read
	assign fwd     = (wr_valid_q && (wr_addr_q == inc_addr)) ? wr_data_q : rd_q;
	assign inc_val = (&fwd) ? fwd : fwd + 1'b1;

	always_ff @(posedge clk) begin
		if (clear_step) begin
			mem_q[clr_q] <= '0;
		end else if (inc_en) begin
			mem_q[inc_addr] <= inc_val;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			wr_valid_q <= 1'b0;
		end else begin
			if (clear_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (inc_en) begin
				wr_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (inc_en) begin
			wr_addr_q <= inc_addr;
			wr_data_q <= inc_val;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cch_datapath.sv =====
// cch_datapath: config registers, hit lists, pair walk pipeline, histogram
// and output register; depends on cch_pkg, cch_hit_list, cch_hist
`default_nettype none

module cch_datapath #(
	parameter int MAX_HITS     = cch_pkg::MAX_HITS_DEF,
	parameter int MAX_COUNTERS = cch_pkg::MAX_COUNTERS_DEF,
	parameter int TIME_WIDTH   = cch_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [cch_pkg::CIDX_W-1:0]   cfg_index,
	input  wire logic [cch_pkg::WIN_W-1:0]    cfg_data,
	input  wire logic [cch_pkg::ID_W-1:0]     hit_id,
	input  wire logic [TIME_WIDTH-1:0]        hit_time,
	input  wire logic [cch_pkg::BIN_W-1:0]    bin_first,
	input  wire logic [cch_pkg::BIN_W-1:0]    bin_second,
	input  wire cch_pkg::cch_cmd_t            cmd,
	output cch_pkg::cch_status_t              status,
	output logic                              event_done,
	output logic [cch_pkg::EVT_W-1:0]         event_coincidences,
	output logic                              hits_dropped,
	output logic [cch_pkg::CNT_W-1:0]         bin_count
);

	localparam int HA_W = $clog2(MAX_HITS);
	localparam int HC_W = $clog2(MAX_HITS + 1);
	localparam int CW   = $clog2(MAX_COUNTERS);
	localparam int DW   = (TIME_WIDTH > cch_pkg::WIN_W) ? TIME_WIDTH : cch_pkg::WIN_W;
	localparam int IW   = cch_pkg::ID_W;
	localparam logic [IW:0]   MC_LIM   = MAX_COUNTERS[IW:0];
	localparam logic [HC_W-1:0] FULL_CNT = MAX_HITS[HC_W-1:0];

	// configuration
	logic [IW-1:0]              first_low_q, first_high_q, second_low_q, second_high_q;
	logic [cch_pkg::WIN_W-1:0]  window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_low_q   <= cch_pkg::FIRST_LOW_RST;
			first_high_q  <= cch_pkg::FIRST_HIGH_RST;
			second_low_q  <= cch_pkg::SECOND_LOW_RST;
			second_high_q <= cch_pkg::SECOND_HIGH_RST;
			window_q      <= cch_pkg::WINDOW_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cch_pkg::REG_FIRST_LOW:   first_low_q   <= cfg_data[IW-1:0];
				cch_pkg::REG_FIRST_HIGH:  first_high_q  <= cfg_data[IW-1:0];
				cch_pkg::REG_SECOND_LOW:  second_low_q  <= cfg_data[IW-1:0];
				cch_pkg::REG_SECOND_HIGH: second_high_q <= cfg_data[IW-1:0];
				cch_pkg::REG_WINDOW:      window_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// hit sorting into the two lists
	logic [HC_W-1:0] cnt1_q, cnt2_q;
	logic            ovf_q;
	logic            in1, in2, full1, full2, wr1, wr2;
	logic [IW-1:0]   off1_in, off2_in;

	assign in1     = (hit_id >= first_low_q) && (hit_id <= first_high_q);
	assign in2     = !in1 && (hit_id >= second_low_q) && (hit_id <= second_high_q);
	assign full1   = (cnt1_q == FULL_CNT);
	assign full2   = (cnt2_q == FULL_CNT);
	assign wr1     = cmd.hit_load && in1 && !full1;
	assign wr2     = cmd.hit_load && in2 && !full2;
	assign off1_in = hit_id - first_low_q;
	assign off2_in = hit_id - second_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q <= '0;
			cnt2_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.evt_close) begin
			cnt1_q <= '0;
			cnt2_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.hit_load) begin
			if (wr1) begin
				cnt1_q <= cnt1_q + 1'b1;
			end
			if (wr2) begin
				cnt2_q <= cnt2_q + 1'b1;
			end
			if ((in1 && full1) || (in2 && full2)) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// pair walk counters
	logic [HA_W-1:0] i_q, j_q;
	logic            row_end;
	logic            walk_empty;
	logic            walk_last;

	assign row_end = (j_q == i_q) || ((HC_W'(j_q) + 1'b1) == cnt2_q);

	assign walk_empty = (cnt1_q == '0) || (cnt2_q == '0);
	assign walk_last  = row_end && ((HC_W'(i_q) + 1'b1) == cnt1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.walk_init) begin
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.walk_issue) begin
			if (row_end) begin
				i_q <= i_q + 1'b1;
				j_q <= '0;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	// list memories, read data forms stage 1
	logic [IW-1:0]         off1_s1, off2_s1;
	logic [TIME_WIDTH-1:0] t1_s1, t2_s1;

	cch_hit_list #(
		.DEPTH (MAX_HITS),
		.TW    (TIME_WIDTH)
	) u_list_first (
		.clk     (clk),
		.wr_en   (wr1),
		.wr_addr (cnt1_q[HA_W-1:0]),
		.wr_off  (off1_in),
		.wr_time (hit_time),
		.rd_en   (cmd.walk_issue),
		.rd_addr (i_q),
		.rd_off  (off1_s1),
		.rd_time (t1_s1)
	);

	cch_hit_list #(
		.DEPTH (MAX_HITS),
		.TW    (TIME_WIDTH)
	) u_list_second (
		.clk     (clk),
		.wr_en   (wr2),
		.wr_addr (cnt2_q[HA_W-1:0]),
		.wr_off  (off2_in),
		.wr_time (hit_time),
		.rd_en   (cmd.walk_issue),
		.rd_addr (j_q),
		.rd_off  (off2_s1),
		.rd_time (t2_s1)
	);

	// pipeline: s1 list data, s2 distance, s3 window match and bin update
	logic                  valid_s1, valid_s2, match_s3;
	logic [TIME_WIDTH-1:0] diff_s2;
	logic [IW-1:0]         off1_s2, off2_s2;
	logic                  bin_ok_s3;
	logic [2*CW-1:0]       addr_s3;
	logic                  bin_ok_s2;
	logic                  near_s2;
	logic [2*CW-1:0]       addr_s2;
	logic                  pipe_busy;

	assign bin_ok_s2 = ({1'b0, off1_s2} < MC_LIM) && ({1'b0, off2_s2} < MC_LIM);
	assign addr_s2   = {off1_s2[CW-1:0], off2_s2[CW-1:0]};
	assign near_s2   = DW'(diff_s2) < DW'(window_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			match_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.walk_issue;
			valid_s2 <= valid_s1;
			match_s3 <= valid_s2 && near_s2;
		end
	end

	always_ff @(posedge clk) begin
		diff_s2   <= (t1_s1 > t2_s1) ? (t1_s1 - t2_s1) : (t2_s1 - t1_s1);
		off1_s2   <= off1_s1;
		off2_s2   <= off2_s1;
		bin_ok_s3 <= bin_ok_s2;
		addr_s3   <= addr_s2;
	end

	assign pipe_busy = valid_s1 || valid_s2 || match_s3;

	// event coincidence total
	logic [cch_pkg::EVT_W-1:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.walk_init) begin
			total_q <= '0;
		end else if (match_s3 && !(&total_q)) begin
			total_q <= total_q + 1'b1;
		end
	end

	// histogram
	logic [IW-1:0]             bf_ext, bs_ext;
	logic                      read_ok;
	logic                      read_ok_q;
	logic [2*CW-1:0]           hist_rd_addr;
	logic [cch_pkg::CNT_W-1:0] hist_rd_data;
	logic                      hist_clear_last;

	assign bf_ext  = {{(IW - cch_pkg::BIN_W){1'b0}}, bin_first};
	assign bs_ext  = {{(IW - cch_pkg::BIN_W){1'b0}}, bin_second};
	assign read_ok = ({1'b0, bf_ext} < MC_LIM) && ({1'b0, bs_ext} < MC_LIM);
	assign hist_rd_addr = cmd.read_issue ? {bf_ext[CW-1:0], bs_ext[CW-1:0]} : addr_s2;

	cch_hist #(
		.CW (CW)
	) u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear_step (cmd.clear_step),
		.clear_last (hist_clear_last),
		.rd_en      (cmd.read_issue || valid_s2),
		.rd_addr    (hist_rd_addr),
		.rd_data    (hist_rd_data),
		.inc_en     (match_s3 && bin_ok_s3),
		.inc_addr   (addr_s3)
	);

	always_ff @(posedge clk) begin
		if (cmd.read_issue) begin
			read_ok_q <= read_ok;
		end
	end

	assign status = '{
		clear_last: hist_clear_last,
		walk_empty: walk_empty,
		walk_last:  walk_last,
		pipe_busy:  pipe_busy
	};

	// output register
	logic                      done_q;
	logic [cch_pkg::EVT_W-1:0] coin_q;
	logic                      drop_q;
	logic [cch_pkg::CNT_W-1:0] bin_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load_evt) begin
			done_q <= 1'b1;
			coin_q <= total_q;
			drop_q <= ovf_q;
			bin_q  <= '0;
		end else if (cmd.out_load_read) begin
			done_q <= 1'b0;
			coin_q <= '0;
			drop_q <= 1'b0;
			bin_q  <= read_ok_q ? hist_rd_data : '0;
		end
	end

	assign event_done         = done_q;
	assign event_coincidences = coin_q;
	assign hits_dropped       = drop_q;
	assign bin_count          = bin_q;

endmodule

`default_nettype wire

// ===== rtl/core/counter_coincidence_histogram.sv =====
// counter_coincidence_histogram: top level joining controller and datapath
// depends on cch_pkg, cch_ctrl, cch_datapath
//
// channel  signals                                  direction
// in       in_valid/in_ready, operation, hit_id,    request in
//          hit_time, end_of_event, bin_first/second
// out      out_valid/out_ready, event_done,         request out
//          event_coincidences, hits_dropped, bin_count
// cfg      cfg_wr_en, cfg_index, cfg_data           write only
//
// a hit that does not close an event is taken in ST_IDLE; a bin read passes
// through ST_READ and waits there for a free output register.
// a closing hit walks the pairs (j <= i) in ST_WALK, then passes ST_DRAIN and ST_DONE,
// at one pair per cycle through the list memory read ports.
// after reset a clearing sweep over all 2**(2*clog2(MAX_COUNTERS)) entries (1024 at
// defaults) zeroes the histogram while in_ready stays low.
// a stalled output holds the controller in ST_DONE or ST_READ; hits are taken while a result waits.
`default_nettype none

module counter_coincidence_histogram #(
	parameter int MAX_HITS     = cch_pkg::MAX_HITS_DEF,
	parameter int MAX_COUNTERS = cch_pkg::MAX_COUNTERS_DEF,
	parameter int TIME_WIDTH   = cch_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [cch_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [cch_pkg::WIN_W-1:0]  cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       operation,
	input  wire logic [cch_pkg::ID_W-1:0]   hit_id,
	input  wire logic [TIME_WIDTH-1:0]      hit_time,
	input  wire logic                       end_of_event,
	input  wire logic [cch_pkg::BIN_W-1:0]  bin_first,
	input  wire logic [cch_pkg::BIN_W-1:0]  bin_second,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            event_done,
	output logic [cch_pkg::EVT_W-1:0]       event_coincidences,
	output logic                            hits_dropped,
	output logic [cch_pkg::CNT_W-1:0]       bin_count
);

	cch_pkg::cch_cmd_t    cmd;
	cch_pkg::cch_status_t status;

	cch_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.end_of_event (end_of_event),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cmd          (cmd),
		.status       (status)
	);

	cch_datapath #(
		.MAX_HITS     (MAX_HITS),
		.MAX_COUNTERS (MAX_COUNTERS),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.hit_id             (hit_id),
		.hit_time           (hit_time),
		.bin_first          (bin_first),
		.bin_second         (bin_second),
		.cmd                (cmd),
		.status             (status),
		.event_done         (event_done),
		.event_coincidences (event_coincidences),
		.hits_dropped       (hits_dropped),
		.bin_count          (bin_count)
	);

endmodule

`default_nettype wire
